/* hw/rtl/lcdnws_pkg.sv */
// Shared types and constants for the character LCD nibble write sequencer.
package lcdnws_pkg;

   typedef enum logic [2:0] {
      CMD_CHAR    = 3'd0,
      CMD_INSTR   = 3'd1,
      CMD_CURSOR  = 3'd2,
      CMD_INIT    = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_HOME    = 3'd5,
      CMD_DISPLAY = 3'd6,
      CMD_ENTRY   = 3'd7
   } command_type;

   localparam int unsigned NUM_INIT_BYTES = 5;
   localparam int unsigned BYTE_IDX_W = $clog2(NUM_INIT_BYTES);

   typedef logic [BYTE_IDX_W-1:0] byte_idx_type;
   typedef logic [1:0] phase_type;

   localparam phase_type PHASE_HI_HIGH = 2'd0;
   localparam phase_type PHASE_HI_LOW  = 2'd1;
   localparam phase_type PHASE_LO_HIGH = 2'd2;
   localparam phase_type PHASE_LO_LOW  = 2'd3;

   localparam logic [7:0] INIT_BYTES [NUM_INIT_BYTES] = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h06};
   localparam logic [4:0] INIT_EXTRA [NUM_INIT_BYTES] = '{5'd20, 5'd1, 5'd11, 5'd20, 5'd11};

   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] LCD_HOME      = 8'h02;
   localparam logic [7:0] LCD_DISPLAY   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY     = 8'h06;
   localparam logic [7:0] LCD_ROW1_BASE = 8'h80;

   localparam logic [4:0] EXTRA_NONE   = 5'd0;
   localparam logic [4:0] EXTRA_CURSOR = 5'd1;
   localparam logic [4:0] EXTRA_SHORT  = 5'd10;

   localparam logic [7:0] POWER_UP_HOLD_MS = 8'd200;

   localparam logic CSR_ENABLE_HALF = 1'b0;
   localparam logic CSR_BYTE_GAP    = 1'b1;

   localparam logic [3:0] ENABLE_HALF_RESET = 4'd2;
   localparam logic [3:0] BYTE_GAP_RESET    = 4'd1;

   typedef struct packed {
      logic         load;
      logic         emit;
      logic         idle_evt;
      byte_idx_type byte_idx;
      phase_type    phase;
      logic         last;
   } ctl_type;

endpackage

/* hw/rtl/lcdnws_ctrl.sv */
// Controller state machine that steps through the pin events of one request.
module lcdnws_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_command,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lcdnws_pkg::ctl_type   ctl
);
   import lcdnws_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POWER_UP,
      ST_BYTES
   } state_type;

   state_type    state_ff, state_in;
   byte_idx_type byte_idx_ff, byte_idx_in;
   phase_type    phase_ff, phase_in;
   logic         init_ff, init_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         slot_free;
   logic         last_evt;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign last_evt  = (state_ff == ST_BYTES) && (phase_ff == PHASE_LO_LOW) &&
                      (!init_ff || (byte_idx_ff == BYTE_IDX_W'(NUM_INIT_BYTES - 1)));

   always_comb begin
      ctl.load     = req_valid && (state_ff == ST_IDLE);
      ctl.emit     = slot_free && (state_ff != ST_IDLE);
      ctl.idle_evt = (state_ff == ST_POWER_UP);
      ctl.byte_idx = byte_idx_ff;
      ctl.phase    = phase_ff;
      ctl.last     = last_evt;

      state_in     = state_ff;
      byte_idx_in  = byte_idx_ff;
      phase_in     = phase_ff;
      init_in      = init_ff;
      rsp_valid_in = ctl.emit || (rsp_valid_ff && !rsp_ready);

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.load) begin
               init_in     = (command_type'(req_command) == CMD_INIT);
               byte_idx_in = '0;
               phase_in    = PHASE_HI_HIGH;
               state_in    = init_in ? ST_POWER_UP : ST_BYTES;
            end
         end
         ST_POWER_UP: begin
            if (slot_free) begin
               state_in = ST_BYTES;
            end
         end
         ST_BYTES: begin
            if (slot_free) begin
               phase_in = phase_type'(phase_ff + 2'd1);
               if (last_evt) begin
                  state_in = ST_IDLE;
               end else if (phase_ff == PHASE_LO_LOW) begin
                  byte_idx_in = byte_idx_type'(byte_idx_ff + 1'b1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_idx_ff  <= '0;
         phase_ff     <= PHASE_HI_HIGH;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_idx_ff  <= byte_idx_in;
         phase_ff     <= phase_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/lcdnws_datapath.sv */
// Datapath with timing registers, request byte selection and the event output register.
module lcdnws_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lcdnws_pkg::ctl_type ctl,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [3:0]          csr_write_data,
   input  logic [2:0]          req_command,
   input  logic [7:0]          req_byte_value,
   input  logic [7:0]          req_row,
   input  logic [7:0]          req_column,
   output logic [3:0]          rsp_nibble,
   output logic                rsp_reg_select,
   output logic                rsp_enable_level,
   output logic [7:0]          rsp_hold_ms,
   output logic                rsp_last
);
   import lcdnws_pkg::*;

   logic [3:0] enable_half_ff, byte_gap_ff;
   logic [7:0] byte_ff, byte_in;
   logic [4:0] extra_ff, extra_in;
   logic       rs_ff, rs_in;
   logic       init_ff;

   logic [3:0] nibble_ff, nibble_in;
   logic       rsel_ff, rsel_in;
   logic       en_ff, en_in;
   logic [7:0] hold_ff, hold_in;
   logic       last_ff;

   logic       col_ok;
   logic [3:0] col_m1;
   logic [7:0] cursor_addr;
   logic [7:0] cur_byte;
   logic [4:0] cur_extra;

   assign col_m1      = 4'(req_column - 8'd1);
   assign col_ok      = (req_column >= 8'd1) && (req_column <= 8'd16);
   assign cursor_addr = (col_ok && (req_row == 8'd1 || req_row == 8'd2)) ?
                        {1'b1, (req_row == 8'd2), 2'b00, col_m1} : LCD_ROW1_BASE;

   always_comb begin
      byte_in  = req_byte_value;
      extra_in = EXTRA_SHORT;
      rs_in    = 1'b0;
      unique case (command_type'(req_command))
         CMD_CHAR: begin
            rs_in    = 1'b1;
            extra_in = EXTRA_NONE;
         end
         CMD_INSTR:   extra_in = EXTRA_NONE;
         CMD_CURSOR: begin
            byte_in  = cursor_addr;
            extra_in = EXTRA_CURSOR;
         end
         CMD_INIT:    byte_in = INIT_BYTES[0];
         CMD_CLEAR:   byte_in = LCD_CLEAR;
         CMD_HOME:    byte_in = LCD_HOME;
         CMD_DISPLAY: byte_in = LCD_DISPLAY;
         CMD_ENTRY:   byte_in = LCD_ENTRY;
         default:     byte_in = req_byte_value;
      endcase
   end

   always_comb begin
      cur_byte  = init_ff ? INIT_BYTES[ctl.byte_idx] : byte_ff;
      cur_extra = init_ff ? INIT_EXTRA[ctl.byte_idx] : extra_ff;
      rsel_in   = init_ff ? 1'b0 : rs_ff;
      nibble_in = (ctl.phase == PHASE_HI_HIGH || ctl.phase == PHASE_HI_LOW) ?
                  cur_byte[7:4] : cur_byte[3:0];
      en_in     = (ctl.phase == PHASE_HI_HIGH || ctl.phase == PHASE_LO_HIGH);
      hold_in   = {4'd0, enable_half_ff};
      if (ctl.phase == PHASE_LO_LOW) begin
         hold_in = 8'({4'd0, enable_half_ff} + {4'd0, byte_gap_ff} + {3'd0, cur_extra});
      end
      if (ctl.idle_evt) begin
         nibble_in = 4'd0;
         rsel_in   = 1'b0;
         en_in     = 1'b0;
         hold_in   = POWER_UP_HOLD_MS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_half_ff <= ENABLE_HALF_RESET;
         byte_gap_ff    <= BYTE_GAP_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ENABLE_HALF) begin
            enable_half_ff <= csr_write_data;
         end else begin
            byte_gap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         byte_ff  <= byte_in;
         extra_ff <= extra_in;
         rs_ff    <= rs_in;
         init_ff  <= (command_type'(req_command) == CMD_INIT);
      end
      if (ctl.emit) begin
         nibble_ff <= nibble_in;
         rsel_ff   <= rsel_in;
         en_ff     <= en_in;
         hold_ff   <= hold_in;
         last_ff   <= ctl.last;
      end
   end

   assign rsp_nibble       = nibble_ff;
   assign rsp_reg_select   = rsel_ff;
   assign rsp_enable_level = en_ff;
   assign rsp_hold_ms      = hold_ff;
   assign rsp_last         = last_ff;

endmodule

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// Top level of the character LCD 4-bit nibble write sequencer.
// Usage: a request on the req_ channel names a command (character, instruction,
// cursor move, initialization, clear, home, display on, entry mode) with its
// byte and cursor position. The block turns it into a series of pin events on
// the rsp_ channel: nibble for D4-D7, RS, enable level and a hold time in ms,
// with rsp_last marking the final event of the request.
// On a taken request the command byte and controller state are registered;
// the first event then goes into the output register once that is free.
// Throughput: one event per cycle while the receiver takes them; a byte takes
// 4 events, initialization 21. The event sequencer takes one request at a time
// and takes the next only after the final event of the current one is emitted.
// The csr_ port sets enable_half_ms (index 0) and byte_gap_ms (index 1); write
// it only while the block is idle.
// Reset brings the timing registers to 2 ms and 1 ms and empties the output.
// When the receiver stalls, the pending event holds in the output register and
// the sequencer waits; nothing is lost or repeated.
module char_lcd_nibble_write_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_row,
   input  logic [7:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_nibble,
   output logic       rsp_reg_select,
   output logic       rsp_enable_level,
   output logic [7:0] rsp_hold_ms,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [3:0] csr_write_data
);
   import lcdnws_pkg::*;

   ctl_type ctl;

   lcdnws_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctl         (ctl)
   );

   lcdnws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_byte_value   (req_byte_value),
      .req_row          (req_row),
      .req_column       (req_column),
      .rsp_nibble       (rsp_nibble),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_enable_level (rsp_enable_level),
      .rsp_hold_ms      (rsp_hold_ms),
      .rsp_last         (rsp_last)
   );

endmodule
